// ===== src/broker_locator_validator_core_assert.svh =====
// Assertion macros for the broker locator validator.
`ifndef BROKER_LOCATOR_VALIDATOR_CORE_ASSERT_SVH
`define BROKER_LOCATOR_VALIDATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define BLV_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BLV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define BLV_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define BLV_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== src/blv_pkg.sv =====
// Shared constants, types and the prefix table of the broker locator validator.
`default_nettype none

package blv_pkg;

   // Default longest accepted string, in characters.
   localparam int MAX_LEN_DEFAULT = 64;

   // Fixed scheme prefix "mqtt://".
   localparam int PREFIX_LEN = 7;

   // Port value: 17 bits so that the saturated value fits.
   localparam int PORT_WIDTH = 17;
   localparam logic [PORT_WIDTH-1:0] PORT_MAX = 17'd65535;
   localparam logic [PORT_WIDTH-1:0] PORT_SAT = 17'd65536;

   // Byte codes that the scanner tests against.
   localparam logic [7:0] CHAR_END   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DEL   = 8'h7f;
   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // One step handed from the handshake logic to the scanner.
   typedef struct packed {
      logic       fire;
      logic [7:0] char_byte;
   } blv_step_type;

   // Expected byte of the prefix at a given position.
   function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0: b = 8'h6d;   // m
         3'd1: b = 8'h71;   // q
         3'd2: b = 8'h74;   // t
         3'd3: b = 8'h74;   // t
         3'd4: b = 8'h3a;   // :
         3'd5: b = 8'h2f;   // /
         3'd6: b = 8'h2f;   // /
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== src/broker_locator_validator_core.sv =====
// Top level of the broker locator validator: request and response handshakes.
//
// Usage: a locator string is sent one byte per request on req_char_byte, with
// a zero byte closing it. Only the zero byte gives a response: rsp_locator_valid
// is 1 when the string was "mqtt://host:port" with a clean host, a port of
// 1 to 65535 and a length within MAX_LEN. The scanner then clears itself for
// the next string.
// Throughput: one request per cycle while req_ready is high. A request is held
// in an input register and then folded into the scanner state.
// Response: rsp_valid is registered and set when its zero byte moves on.
// Stalls: while a response waits on rsp_ready, byte requests keep flowing; only
// a second zero byte waits in the input register, and req_ready drops while it
// cannot move on.
// Reset: synchronous, active high; clears both handshakes and all scanner
// state, so the first byte after reset starts a new string.
`default_nettype none

`include "broker_locator_validator_core_assert.svh"

module broker_locator_validator_core
   import blv_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_char_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_locator_valid
);

   logic         in_valid_ff;
   logic [7:0]   in_byte_ff;
   logic         rsp_valid_ff;
   logic         rsp_data_ff;
   logic         in_zero;
   logic         advance;
   logic         verdict_ok;
   blv_step_type step;

   // A held byte moves on unless it is an end byte facing a full response slot.
   assign in_zero   = (in_byte_ff == CHAR_END);
   assign advance   = in_valid_ff && (!in_zero || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign step.fire      = advance;
   assign step.char_byte = in_byte_ff;

   blv_scan #(
      .MAX_LEN (MAX_LEN)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .verdict_ok (verdict_ok)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_char_byte;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_zero) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_zero) begin
         rsp_data_ff <= verdict_ok;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_locator_valid = rsp_data_ff;

   // An end byte that moves on always leaves a response behind.
   `BLV_ASSERT_NEXT(a_end_gives_rsp, clock, reset, advance && in_zero, rsp_valid_ff, "end byte lost its response")

   // A plain byte never creates a response of its own.
   `BLV_ASSERT_NEXT(a_byte_no_rsp, clock, reset, advance && !in_zero && !(rsp_valid_ff && !rsp_ready), !rsp_valid_ff, "plain byte produced a response")

   // Back-pressure only ever comes from a blocked end byte.
   `BLV_ASSERT_IMPLY(a_ready_low_cause, clock, reset, !req_ready, in_valid_ff && in_zero && rsp_valid_ff && !rsp_ready, "request stalled without a blocked end byte")

endmodule

`default_nettype wire

// ===== src/blv_scan.sv =====
// Per-byte scanner state and the verdict for the string seen so far.
`default_nettype none

module blv_scan
   import blv_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire blv_step_type step,
   output logic              verdict_ok
);

   localparam int CountWidth = $clog2(MAX_LEN + 2);
   localparam logic [CountWidth-1:0] CountPrefix = CountWidth'(PREFIX_LEN);
   localparam logic [CountWidth-1:0] CountMax    = CountWidth'(MAX_LEN);
   localparam logic [CountWidth-1:0] CountSat    = CountWidth'(MAX_LEN + 1);

   logic [CountWidth-1:0] char_count_ff, char_count_in;
   logic                  prefix_ok_ff, prefix_ok_in;
   logic                  host_bad_ff, host_bad_in;
   logic                  colon_seen_ff, colon_seen_in;
   logic                  colon_at_start_ff, colon_at_start_in;
   logic [PORT_WIDTH-1:0] port_value_ff, port_value_in;
   logic                  port_non_digit_ff, port_non_digit_in;
   logic                  port_nonempty_ff, port_nonempty_in;

   logic [7:0]  c;
   logic        is_digit;
   logic [20:0] port_next;

   assign c        = step.char_byte;
   assign is_digit = c inside {[CHAR_ZERO:CHAR_NINE]};

   // Running decimal value; the low nibble of an ASCII digit is its value.
   assign port_next = 21'(port_value_ff) * 21'd10 + {17'd0, c[3:0]};

   // Verdict on the string as it stands; used when the end byte arrives.
   assign verdict_ok = (char_count_ff >= CountPrefix) && (char_count_ff <= CountMax)
                       && prefix_ok_ff && colon_seen_ff && !colon_at_start_ff
                       && !host_bad_ff && port_nonempty_ff && !port_non_digit_ff
                       && (port_value_ff != '0) && (port_value_ff <= PORT_MAX);

   // Next state for one byte.
   always_comb begin
      char_count_in     = char_count_ff;
      prefix_ok_in      = prefix_ok_ff;
      host_bad_in       = host_bad_ff;
      colon_seen_in     = colon_seen_ff;
      colon_at_start_in = colon_at_start_ff;
      port_value_in     = port_value_ff;
      port_non_digit_in = port_non_digit_ff;
      port_nonempty_in  = port_nonempty_ff;
      if (step.fire) begin
         if (c == CHAR_END) begin
            char_count_in     = '0;
            prefix_ok_in      = 1'b1;
            host_bad_in       = 1'b0;
            colon_seen_in     = 1'b0;
            colon_at_start_in = 1'b0;
            port_value_in     = '0;
            port_non_digit_in = 1'b0;
            port_nonempty_in  = 1'b0;
         end else begin
            if (char_count_ff != CountSat) begin
               char_count_in = char_count_ff + 1'b1;
            end
            if (char_count_ff < CountPrefix) begin
               if (c != prefix_byte(char_count_ff[2:0])) begin
                  prefix_ok_in = 1'b0;
               end
            end else begin
               if ((c <= CHAR_SPACE) || (c == CHAR_DEL)) begin
                  host_bad_in = 1'b1;
               end
               if (c == CHAR_COLON) begin
                  colon_seen_in     = 1'b1;
                  colon_at_start_in = (char_count_ff == CountPrefix);
                  port_value_in     = '0;
                  port_non_digit_in = 1'b0;
                  port_nonempty_in  = 1'b0;
               end else begin
                  port_nonempty_in = 1'b1;
                  if (is_digit) begin
                     port_value_in = (port_next > 21'(PORT_MAX)) ? PORT_SAT
                                                                 : port_next[16:0];
                  end else begin
                     port_non_digit_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff     <= '0;
         prefix_ok_ff      <= 1'b1;
         host_bad_ff       <= 1'b0;
         colon_seen_ff     <= 1'b0;
         colon_at_start_ff <= 1'b0;
         port_value_ff     <= '0;
         port_non_digit_ff <= 1'b0;
         port_nonempty_ff  <= 1'b0;
      end else begin
         char_count_ff     <= char_count_in;
         prefix_ok_ff      <= prefix_ok_in;
         host_bad_ff       <= host_bad_in;
         colon_seen_ff     <= colon_seen_in;
         colon_at_start_ff <= colon_at_start_in;
         port_value_ff     <= port_value_in;
         port_non_digit_ff <= port_non_digit_in;
         port_nonempty_ff  <= port_nonempty_in;
      end
   end

endmodule

`default_nettype wire

// ===== test/broker_locator_validator_core_test.sv =====
// Self-checking testbench for the broker locator validator core.
`timescale 1ns / 1ps

module broker_locator_validator_core_test;
   import blv_pkg::*;

   typedef logic [7:0] byte_queue_type [$];

   // How the verdict of a directed string is known.
   typedef enum {
      VERDICT_REJECT,
      VERDICT_ACCEPT,
      VERDICT_PREDICTED
   } verdict_type;

   // Ready patterns of the response side.
   typedef enum {
      RX_STEADY,
      RX_COIN,
      RX_SPARSE,
      RX_HOLD
   } rx_pattern_type;

   // One directed string: head, then pad_len filler bytes, then tail.
   typedef struct {
      string       head;
      int          pad_len;
      string       tail;
      verdict_type verdict;
   } locator_case_type;

   localparam string SCHEME_TEXT = "mqtt://";
   localparam int RANDOM_BYTES = 950;
   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_CASES = 25;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_locator_valid;

   // Scanner state of the predictor.
   logic [6:0]            str_len;
   logic                  scheme_match;
   logic                  host_dirty;
   logic                  colon_found;
   logic                  colon_at_host_start;
   logic [PORT_WIDTH-1:0] port_num;
   logic                  port_dirty;
   logic                  port_started;

   logic           expected_verdicts [$];
   int             errors = 0;
   int             verdicts_checked = 0;
   int             valid_verdicts = 0;
   int             strings_sent = 0;
   int             bytes_sent = 0;
   int             burst_left = 0;
   int             cycles = 0;
   int             rx_left = 0;
   rx_pattern_type rx_pattern = RX_STEADY;
   logic           wanted;

   locator_case_type directed_cases [NUM_CASES] = '{
      '{"", 0, "", VERDICT_REJECT},
      '{"mqtt:/", 0, "", VERDICT_REJECT},
      '{"mqtt://", 0, "", VERDICT_REJECT},
      '{"mqtt://h:1", 0, "", VERDICT_ACCEPT},
      '{"mqtt://h:65535", 0, "", VERDICT_ACCEPT},
      '{"mqtt://h:65536", 0, "", VERDICT_REJECT},
      '{"mqtt://h:0", 0, "", VERDICT_REJECT},
      '{"mqtt://h:0080", 0, "", VERDICT_ACCEPT},
      '{"mqtt://:80", 0, "", VERDICT_REJECT},
      '{"mqtt://h:", 0, "", VERDICT_REJECT},
      '{"mqtt://h h:80", 0, "", VERDICT_REJECT},
      '{"mqtt://h:8 0", 0, "", VERDICT_REJECT},
      '{"mqtt://h\177:80", 0, "", VERDICT_REJECT},
      '{"mqtt://h\001:1", 0, "", VERDICT_REJECT},
      '{"mqtt://h:8a", 0, "", VERDICT_REJECT},
      '{"mqtt://a:b:80", 0, "", VERDICT_ACCEPT},
      '{"mqtt://h:80:", 0, "", VERDICT_REJECT},
      '{"Mqtt://h:80", 0, "", VERDICT_REJECT},
      '{"mqtt://h:99999999999", 0, "", VERDICT_REJECT},
      '{"mqtt://\377\200:1", 0, "", VERDICT_PREDICTED},
      '{"mqtt://", 55, ":1", VERDICT_ACCEPT},
      '{"mqtt://", 56, ":1", VERDICT_REJECT},
      '{"mqtt://", 200, ":80", VERDICT_REJECT},
      '{"mqtt://[::1]:1883", 0, "", VERDICT_PREDICTED},
      '{"mqtt://broker.local:8883", 0, "", VERDICT_PREDICTED}
   };

   broker_locator_validator_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_byte     (req_char_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_locator_valid (rsp_locator_valid)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Start every string from a clean scanner.
   task automatic clear_scanner();
      str_len = '0;
      scheme_match = 1'b1;
      host_dirty = 1'b0;
      colon_found = 1'b0;
      colon_at_host_start = 1'b0;
      port_num = '0;
      port_dirty = 1'b0;
      port_started = 1'b0;
   endtask

   // Fold one byte into the predicted scanner state; the end byte yields a verdict.
   task automatic scan_locator_byte(input logic [7:0] b, output logic done,
                                    output logic ok);
      logic [6:0]  pos;
      int unsigned next_port;
      pos = str_len;
      done = 1'b0;
      ok = 1'b0;
      if (b == CHAR_END) begin
         done = 1'b1;
         ok = str_len >= PREFIX_LEN && str_len <= MAX_LEN_DEFAULT && scheme_match
              && colon_found && !colon_at_host_start && !host_dirty && port_started
              && !port_dirty && port_num >= 1 && port_num <= PORT_MAX;
         clear_scanner();
      end else begin
         if (str_len < MAX_LEN_DEFAULT + 1) begin
            str_len = str_len + 1'b1;
         end
         if (pos < PREFIX_LEN) begin
            if (b != SCHEME_TEXT[pos]) begin
               scheme_match = 1'b0;
            end
         end else begin
            if (b <= CHAR_SPACE || b == CHAR_DEL) begin
               host_dirty = 1'b1;
            end
            if (b == CHAR_COLON) begin
               // A new colon restarts the port and moves the host boundary.
               colon_found = 1'b1;
               colon_at_host_start = (pos == PREFIX_LEN);
               port_num = '0;
               port_dirty = 1'b0;
               port_started = 1'b0;
            end else begin
               port_started = 1'b1;
               if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                  next_port = port_num * 10 + (b - CHAR_ZERO);
                  port_num = (next_port > PORT_MAX) ? PORT_SAT : next_port[PORT_WIDTH-1:0];
               end else begin
                  port_dirty = 1'b1;
               end
            end
         end
      end
   endtask

   // Offer one byte in bursts with random gaps, and predict once it is taken.
   task automatic send_byte(input logic [7:0] b, input verdict_type verdict);
      int   gap;
      logic done;
      logic ok;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_char_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      scan_locator_byte(b, done, ok);
      if (done) begin
         if (verdict == VERDICT_PREDICTED) begin
            expected_verdicts.push_back(ok);
         end else begin
            expected_verdicts.push_back(verdict == VERDICT_ACCEPT);
         end
      end
   endtask

   // Send a whole string followed by its end byte.
   task automatic send_string(input byte_queue_type text, input verdict_type verdict);
      foreach (text[i]) begin
         send_byte(text[i], verdict);
      end
      send_byte(CHAR_END, verdict);
      strings_sent++;
   endtask

   // Mostly well-formed locators with random content; some noise and broken prefixes.
   task automatic build_random(output byte_queue_type text);
      int          shape;
      int          host_len;
      int          port_kind;
      int unsigned port;
      string       digits;
      text = {};
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
         // Noise: any non-zero bytes.
         repeat ($urandom_range(0, 14)) text.push_back(8'($urandom_range(1, 255)));
      end else begin
         for (int i = 0; i < PREFIX_LEN; i++) begin
            text.push_back(SCHEME_TEXT[i]);
         end
         if (shape == 1) begin
            // Broken prefix: cut short or with one byte changed.
            if ($urandom_range(0, 1) == 0) begin
               repeat ($urandom_range(1, PREFIX_LEN)) void'(text.pop_back());
            end else begin
               text[$urandom_range(0, PREFIX_LEN - 1)] = 8'($urandom_range(1, 255));
            end
         end
         host_len = ($urandom_range(0, 9) == 0) ? $urandom_range(45, 62)
                                                : $urandom_range(0, 12);
         repeat (host_len) begin
            case ($urandom_range(0, 19))
               0, 1:    text.push_back(8'($urandom_range(1, 255)));
               2:       text.push_back(CHAR_COLON);
               default: text.push_back(8'($urandom_range(8'h21, 8'h7e)));
            endcase
         end
         if ($urandom_range(0, 9) != 0) begin
            text.push_back(CHAR_COLON);
         end
         port_kind = $urandom_range(0, 9);
         case (port_kind)
            0:       port = 0;
            1, 2:    port = $urandom_range(65530, 65545);
            3:       port = $urandom;
            default: port = $urandom_range(1, 65535);
         endcase
         digits = $sformatf("%0d", port);
         if ($urandom_range(0, 7) == 0) begin
            digits = {"00", digits};
         end
         if (port_kind == 9 && $urandom_range(0, 1) == 0) begin
            digits = "";
         end
         for (int i = 0; i < digits.len(); i++) begin
            text.push_back(digits[i]);
         end
         // Occasionally spoil the string with a stray byte or the port with a trailing colon.
         case ($urandom_range(0, 11))
            0:       text.insert($urandom_range(0, text.size()), 8'($urandom_range(1, 255)));
            1:       text.push_back(CHAR_COLON);
            default: ;
         endcase
      end
   endtask

   // Stimulus: reset, the directed table, then random strings.
   initial begin
      byte_queue_type text;
      clear_scanner();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_cases[n]) begin
         text = {};
         for (int i = 0; i < directed_cases[n].head.len(); i++) begin
            text.push_back(directed_cases[n].head[i]);
         end
         repeat (directed_cases[n].pad_len) text.push_back("a");
         for (int i = 0; i < directed_cases[n].tail.len(); i++) begin
            text.push_back(directed_cases[n].tail[i]);
         end
         send_string(text, directed_cases[n].verdict);
      end

      while (bytes_sent < RANDOM_BYTES) begin
         build_random(text);
         send_string(text, VERDICT_PREDICTED);
      end
      req_valid <= 1'b0;

      // Drain the outstanding verdicts, then allow for the pipeline.
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Scanned %0d strings in %0d bytes; %0d verdicts checked, %0d of them valid.",
               strings_sent, bytes_sent, verdicts_checked, valid_verdicts);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Response side: compare each verdict and stall on a changing pattern.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            errors++;
            $display("%0t: verdict with no string pending, expected none, got %0b",
                     $time, rsp_locator_valid);
         end else begin
            wanted = expected_verdicts.pop_front();
            verdicts_checked++;
            if (rsp_locator_valid === 1'b1) begin
               valid_verdicts++;
            end
            if (rsp_locator_valid !== wanted) begin
               errors++;
               $display("%0t: verdict mismatch, expected %0b, got %0b",
                        $time, wanted, rsp_locator_valid);
            end
         end
      end
      if (rx_left == 0) begin
         rx_pattern = rx_pattern_type'($urandom_range(0, 3));
         rx_left = $urandom_range(16, 96);
      end
      rx_left--;
      case (rx_pattern)
         RX_STEADY: rsp_ready <= 1'b1;
         RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:   rsp_ready <= (rx_left < 4);
      endcase
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d verdicts outstanding.",
                  cycles, expected_verdicts.size());
         $display("FAILURE");
         $finish;
      end
   end

endmodule
